>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pctd assertion failed");

// next-cycle implication
`define PCTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pctd assertion failed");

`endif

>>> hdl/pctd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg
// Constants, widths and types of the prefix code tree decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

	localparam int MAX_NODES   = 512;
	localparam int STACK_DEPTH = 256;
	localparam int SYMBOL_BITS = 8;
	localparam int BYTE_W      = 8;

	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int NALLOC_W   = $clog2(MAX_NODES + 1);
	localparam int STK_AW     = $clog2(STACK_DEPTH);
	localparam int DEPTH_W    = $clog2(STACK_DEPTH + 1);
	localparam int LEAF_CNT_W = $clog2(SYMBOL_BITS + 1);
	localparam int BIT_IDX_W  = $clog2(BYTE_W);

	typedef struct packed {
		logic                   leaf;
		logic [SYMBOL_BITS-1:0] sym;
		logic [NODE_W-1:0]      left;
		logic [NODE_W-1:0]      right;
	} node_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_TAIL,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic              clear;
		logic              push;
		logic              pop;
		logic              fetch;
		logic [NODE_W-1:0] left;
	} stk_cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0]  tos;
		logic [DEPTH_W-1:0] depth;
	} stk_stat_t;

	typedef struct packed {
		logic                   valid;
		logic                   flush;
		logic                   err;
		logic [SYMBOL_BITS-1:0] sym;
	} res_t;

endpackage

>>> hdl/pctd_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_stack
// Pending node stack: top entry in a register, the rest in a synchronous
// memory; the entry below the top is fetched ahead of a pop.
// ----------------------------------------------------------------------------
module pctd_stack (
	input  logic                clk,
	input  logic                arst_n,
	input  pctd_pkg::stk_cmd_t  cmd,
	output pctd_pkg::stk_stat_t stat
);

	logic [pctd_pkg::NODE_W-1:0]  mem [pctd_pkg::STACK_DEPTH];
	logic [pctd_pkg::NODE_W-1:0]  rd_q;
	logic [pctd_pkg::NODE_W-1:0]  tos_q;
	logic [pctd_pkg::DEPTH_W-1:0] depth_q;
	logic [pctd_pkg::DEPTH_W-1:0] depth_m1;
	logic [pctd_pkg::DEPTH_W-1:0] depth_m2;

	assign depth_m1 = depth_q - pctd_pkg::DEPTH_W'(1);
	assign depth_m2 = depth_q - pctd_pkg::DEPTH_W'(2);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[depth_m1[pctd_pkg::STK_AW-1:0]] <= cmd.left + pctd_pkg::NODE_W'(1);
		end
		if (cmd.fetch) begin
			rd_q <= mem[depth_m2[pctd_pkg::STK_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tos_q   <= '0;
			depth_q <= pctd_pkg::DEPTH_W'(1);
		end else if (cmd.clear) begin
			tos_q   <= '0;
			depth_q <= pctd_pkg::DEPTH_W'(1);
		end else if (cmd.push) begin
			tos_q   <= cmd.left;
			depth_q <= depth_q + pctd_pkg::DEPTH_W'(1);
		end else if (cmd.pop) begin
			tos_q   <= rd_q;
			depth_q <= depth_m1;
		end
	end

	assign stat.tos   = tos_q;
	assign stat.depth = depth_q;

endmodule

>>> hdl/pctd_res.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_res
// Result hold stage and output register; marks the final word of each
// input byte once the byte is known to be finished.
// ----------------------------------------------------------------------------
module pctd_res (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pctd_pkg::res_t                       res,
	output logic                                 can_take,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [pctd_pkg::SYMBOL_BITS-1:0]     symbol,
	output logic                                 last_in_run,
	output logic                                 error
);

	logic                             h_v_q;
	logic                             h_err_q;
	logic [pctd_pkg::SYMBOL_BITS-1:0] h_sym_q;
	logic                             o_v_q;
	logic                             o_err_q;
	logic                             o_last_q;
	logic [pctd_pkg::SYMBOL_BITS-1:0] o_sym_q;
	logic                             o_free;
	logic                             move;
	logic                             take;

	assign o_free   = !o_v_q || out_ready;
	assign can_take = !h_v_q || o_free;
	assign move     = h_v_q && o_free && (res.valid || res.flush);
	assign take     = res.valid && can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_v_q <= 1'b0;
			o_v_q <= 1'b0;
		end else begin
			if (take) begin
				h_v_q <= 1'b1;
			end else if (move) begin
				h_v_q <= 1'b0;
			end
			if (move) begin
				o_v_q <= 1'b1;
			end else if (out_ready) begin
				o_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			o_sym_q  <= h_sym_q;
			o_err_q  <= h_err_q;
			o_last_q <= res.flush;
		end
		if (take) begin
			h_sym_q <= res.sym;
			h_err_q <= res.err;
		end
	end

	assign out_valid   = o_v_q;
	assign symbol      = o_sym_q;
	assign last_in_run = o_last_q;
	assign error       = o_err_q;

endmodule

>>> hdl/pctd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_core
// Byte sequencer with node memory: builds the tree from the pre-order header
// one bit a cycle, then walks it a bit and a node read a cycle unless stalled.
// ----------------------------------------------------------------------------
module pctd_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pctd_pkg::BYTE_W-1:0] data_byte,
	input  logic                        end_of_file,
	output pctd_pkg::stk_cmd_t          cmd,
	input  pctd_pkg::stk_stat_t         stk,
	output pctd_pkg::res_t              res,
	input  logic                        res_can_take
);

	pctd_pkg::node_t                    node_mem [pctd_pkg::MAX_NODES];
	pctd_pkg::node_t                    node_rd_q;
	pctd_pkg::node_t                    node_wd;
	logic                               node_we;
	logic                               node_re;
	logic [pctd_pkg::NODE_W-1:0]        walk_addr;

	pctd_pkg::state_t                   state_q;
	pctd_pkg::state_t                   state_d;
	logic [pctd_pkg::BYTE_W-1:0]        sh_q;
	logic                               eof_q;
	logic [pctd_pkg::BIT_IDX_W-1:0]     cnt_q;
	logic [pctd_pkg::NALLOC_W-1:0]      nodes_q;
	logic [pctd_pkg::LEAF_CNT_W-1:0]    leaf_cnt_q;
	logic [pctd_pkg::SYMBOL_BITS-1:0]   acc_q;
	logic                               hdr_done_q;
	logic                               err_q;
	logic [pctd_pkg::NODE_W-1:0]        cur_left_q;
	logic [pctd_pkg::NODE_W-1:0]        cur_right_q;
	logic                               rd_pend_q;

	logic                               cur_bit;
	logic                               skip;
	logic                               leaf_active;
	logic                               ovf;
	logic                               err_step;
	logic                               hdr_fin;
	logic                               go;
	logic                               pend_leaf;
	logic                               stall;
	logic                               accept;
	logic                               eof_clear;
	logic [pctd_pkg::SYMBOL_BITS-1:0]   acc_nxt;
	logic [pctd_pkg::NODE_W-1:0]        left_idx;
	logic [pctd_pkg::NODE_W-1:0]        eff_left;
	logic [pctd_pkg::NODE_W-1:0]        eff_right;
	logic [pctd_pkg::NALLOC_W:0]        nodes_p2;

	localparam logic [pctd_pkg::NODE_W-1:0] ROOT_LEFT  = pctd_pkg::NODE_W'(1);
	localparam logic [pctd_pkg::NODE_W-1:0] ROOT_RIGHT = pctd_pkg::NODE_W'(2);

	assign cur_bit     = sh_q[pctd_pkg::BYTE_W-1];
	assign skip        = err_q || (hdr_done_q && nodes_q == pctd_pkg::NALLOC_W'(1));
	assign leaf_active = leaf_cnt_q != '0;
	assign acc_nxt     = {acc_q[pctd_pkg::SYMBOL_BITS-2:0], cur_bit};
	assign left_idx    = nodes_q[pctd_pkg::NODE_W-1:0];
	assign nodes_p2    = {1'b0, nodes_q} + (pctd_pkg::NALLOC_W + 1)'(2);
	assign ovf         = (nodes_p2 > (pctd_pkg::NALLOC_W + 1)'(pctd_pkg::MAX_NODES))
		|| (stk.depth >= pctd_pkg::DEPTH_W'(pctd_pkg::STACK_DEPTH));
	assign err_step    = !hdr_done_q && !leaf_active && !cur_bit && ovf;
	assign hdr_fin     = !hdr_done_q && leaf_active
		&& leaf_cnt_q == pctd_pkg::LEAF_CNT_W'(1) && stk.depth == pctd_pkg::DEPTH_W'(1);
	assign pend_leaf   = rd_pend_q && node_rd_q.leaf;
	assign stall       = pend_leaf && !res_can_take;
	assign eff_left    = rd_pend_q ? (node_rd_q.leaf ? ROOT_LEFT : node_rd_q.left)
		: cur_left_q;
	assign eff_right   = rd_pend_q ? (node_rd_q.leaf ? ROOT_RIGHT : node_rd_q.right)
		: cur_right_q;
	assign walk_addr   = cur_bit ? eff_right : eff_left;
	assign in_ready    = (state_q == pctd_pkg::ST_IDLE)
		|| (state_q == pctd_pkg::ST_FLUSH && res_can_take);
	assign accept      = in_valid && in_ready;
	assign eof_clear   = state_q == pctd_pkg::ST_FLUSH && res_can_take && eof_q;

	// node memory
	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[stk.tos] <= node_wd;
		end
		if (node_re) begin
			node_rd_q <= node_mem[walk_addr];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pctd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = pctd_pkg::ST_RUN;
				end
			end
			pctd_pkg::ST_RUN: begin
				if (skip) begin
					state_d = pctd_pkg::ST_FLUSH;
				end else if (go && (err_step || hdr_fin || (&cnt_q))) begin
					state_d = hdr_done_q ? pctd_pkg::ST_TAIL : pctd_pkg::ST_FLUSH;
				end
			end
			pctd_pkg::ST_TAIL: begin
				if (!stall) begin
					state_d = pctd_pkg::ST_FLUSH;
				end
			end
			pctd_pkg::ST_FLUSH: begin
				if (res_can_take) begin
					state_d = in_valid ? pctd_pkg::ST_RUN : pctd_pkg::ST_IDLE;
				end
			end
			default: state_d = pctd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		go         = 1'b0;
		node_we    = 1'b0;
		node_re    = 1'b0;
		node_wd    = '0;
		cmd        = '0;
		cmd.left   = left_idx;
		res        = '0;
		res.sym    = node_rd_q.sym;
		case (state_q)
			pctd_pkg::ST_RUN: begin
				if (!skip && !hdr_done_q) begin
					if (leaf_active) begin
						go = 1'b1;
						if (leaf_cnt_q == pctd_pkg::LEAF_CNT_W'(1)) begin
							node_we      = 1'b1;
							node_wd.leaf = 1'b1;
							node_wd.sym  = acc_nxt;
							cmd.pop      = 1'b1;
						end
					end else if (cur_bit) begin
						go        = 1'b1;
						cmd.fetch = 1'b1;
					end else if (ovf) begin
						res.valid = 1'b1;
						res.err   = 1'b1;
						res.sym   = '0;
						go        = res_can_take;
					end else begin
						go            = 1'b1;
						node_we       = 1'b1;
						node_wd.left  = left_idx;
						node_wd.right = left_idx + pctd_pkg::NODE_W'(1);
						cmd.push      = 1'b1;
					end
				end else if (!skip) begin
					res.valid = pend_leaf;
					go        = !stall;
					node_re   = !stall;
				end
			end
			pctd_pkg::ST_TAIL: begin
				res.valid = pend_leaf;
			end
			pctd_pkg::ST_FLUSH: begin
				res.flush = 1'b1;
				cmd.clear = eof_clear;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pctd_pkg::ST_IDLE;
			cnt_q       <= '0;
			nodes_q     <= pctd_pkg::NALLOC_W'(1);
			leaf_cnt_q  <= '0;
			acc_q       <= '0;
			hdr_done_q  <= 1'b0;
			err_q       <= 1'b0;
			cur_left_q  <= ROOT_LEFT;
			cur_right_q <= ROOT_RIGHT;
			rd_pend_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == pctd_pkg::ST_RUN && !skip && go) begin
				cnt_q <= cnt_q + pctd_pkg::BIT_IDX_W'(1);
			end
			if (eof_clear) begin
				nodes_q     <= pctd_pkg::NALLOC_W'(1);
				leaf_cnt_q  <= '0;
				acc_q       <= '0;
				hdr_done_q  <= 1'b0;
				err_q       <= 1'b0;
				cur_left_q  <= ROOT_LEFT;
				cur_right_q <= ROOT_RIGHT;
				rd_pend_q   <= 1'b0;
			end else if (state_q == pctd_pkg::ST_RUN && !skip && go) begin
				if (!hdr_done_q) begin
					if (leaf_active) begin
						acc_q      <= acc_nxt;
						leaf_cnt_q <= leaf_cnt_q - pctd_pkg::LEAF_CNT_W'(1);
						if (hdr_fin) begin
							hdr_done_q  <= 1'b1;
							cur_left_q  <= ROOT_LEFT;
							cur_right_q <= ROOT_RIGHT;
						end
					end else if (cur_bit) begin
						leaf_cnt_q <= pctd_pkg::LEAF_CNT_W'(pctd_pkg::SYMBOL_BITS);
						acc_q      <= '0;
					end else if (ovf) begin
						err_q <= 1'b1;
					end else begin
						nodes_q <= nodes_q + pctd_pkg::NALLOC_W'(2);
					end
				end else begin
					cur_left_q  <= eff_left;
					cur_right_q <= eff_right;
					rd_pend_q   <= 1'b1;
				end
			end else if (state_q == pctd_pkg::ST_TAIL && !stall) begin
				cur_left_q  <= eff_left;
				cur_right_q <= eff_right;
				rd_pend_q   <= 1'b0;
			end
		end
	end

	// input word shift register
	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q  <= data_byte;
			eof_q <= end_of_file;
		end else if (state_q == pctd_pkg::ST_RUN && !skip && go) begin
			sh_q <= {sh_q[pctd_pkg::BYTE_W-2:0], 1'b0};
		end
	end

endmodule

>>> hdl/prefix_code_tree_decoder_unit.sv
`timescale 1ns / 1ps
// Header byte: one step per bit, then a flush step; when the header ends or overflows inside
// the byte, only the bits used and then the flush. Data byte: one node memory read per bit,
// a tail step for the last read, then a flush. Bytes after an overflow or of a leaf-only
// tree: a skip step, then a flush. Output waits stretch all of these.
// A held symbol moves to the output register with the next symbol of its byte or the flush.
// arst_n clears the control state; the node and stack memories need no clearing pass.
// ----------------------------------------------------------------------------
// prefix_code_tree_decoder_unit
// Prefix code decoder with a pre-order tree header, one byte word in and
// up to eight symbol words out per byte.
// ----------------------------------------------------------------------------
module prefix_code_tree_decoder_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [pctd_pkg::BYTE_W-1:0]      data_byte,
	input  logic                             end_of_file,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pctd_pkg::SYMBOL_BITS-1:0] symbol,
	output logic                             last_in_run,
	output logic                             error
);

	pctd_pkg::stk_cmd_t  cmd;
	pctd_pkg::stk_stat_t stk;
	pctd_pkg::res_t      res;
	logic                res_can_take;

	pctd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_file  (end_of_file),
		.cmd          (cmd),
		.stk          (stk),
		.res          (res),
		.res_can_take (res_can_take)
	);

	pctd_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stk)
	);

	pctd_res u_res (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.can_take    (res_can_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.symbol      (symbol),
		.last_in_run (last_in_run),
		.error       (error)
	);

endmodule

>>> hdl/pctd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pctd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [pctd_pkg::SYMBOL_BITS-1:0] symbol,
	input logic                             last_in_run,
	input logic                             error
);

	`PCTD_ASSERT_NOW(a_err_sym_zero, clk, arst_n, out_valid && error, symbol == '0)
	`PCTD_ASSERT_NOW(a_err_is_last, clk, arst_n, out_valid && error, last_in_run)
	`PCTD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`PCTD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(symbol) && $stable(last_in_run) && $stable(error))

endmodule

bind prefix_code_tree_decoder_unit pctd_checker u_pctd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.symbol      (symbol),
	.last_in_run (last_in_run),
	.error       (error)
);
